[sv/fpa_pkg.sv]
package fpa_pkg;

  localparam int unsigned FPA_FRACTION_BITS = 8;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_LT    = 4'd4,
    CMD_GT    = 4'd5,
    CMD_LE    = 4'd6,
    CMD_GE    = 4'd7,
    CMD_EQ    = 4'd8,
    CMD_NE    = 4'd9,
    CMD_MIN   = 4'd10,
    CMD_MAX   = 4'd11,
    CMD_INC   = 4'd12,
    CMD_DEC   = 4'd13,
    CMD_TOINT = 4'd14
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] res;
    logic        cmp;
    logic        ovf;
    logic        dz;
    logic        neg;
  } ctl_t;

  typedef struct packed {
    logic [31:0] v;
    logic        ovf;
  } sat_t;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  function automatic sat_t clamp_mag(input logic neg, input logic [63:0] mag);
    sat_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.v   = SAT_MIN;
        r.ovf = 1'b1;
      end else begin
        r.v = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        r.v   = SAT_MAX;
        r.ovf = 1'b1;
      end else begin
        r.v = mag[31:0];
      end
    end
    return r;
  endfunction

  function automatic sat_t clamp33(input logic [32:0] s);
    sat_t r;
    r.ovf = s[32] ^ s[31];
    if (r.ovf) begin
      r.v = s[32] ? SAT_MIN : SAT_MAX;
    end else begin
      r.v = s[31:0];
    end
    return r;
  endfunction

endpackage

[sv/fpa_front.sv]
module fpa_front import fpa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FPA_FRACTION_BITS
) (
  input  logic [3:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output ctl_t        ctl_o,
  output logic [31:0] mag_a_o,
  output logic [31:0] mag_b_o
);

  logic signed [31:0] a;
  logic signed [31:0] b;
  logic [32:0] sum;
  logic [32:0] dif;
  logic [32:0] incr;
  logic [32:0] decr;
  sat_t sat;

  assign a = operand_a_i;
  assign b = operand_b_i;
  assign sum  = {a[31], a} + {b[31], b};
  assign dif  = {a[31], a} - {b[31], b};
  assign incr = {a[31], a} + 33'd1;
  assign decr = {a[31], a} - 33'd1;
  assign mag_a_o = a[31] ? 32'd0 - operand_a_i : operand_a_i;
  assign mag_b_o = b[31] ? 32'd0 - operand_b_i : operand_b_i;

  always_comb begin
    ctl_o     = '0;
    ctl_o.cmd = cmd_e'(command_i);
    ctl_o.neg = a[31] ^ b[31];
    sat       = '0;
    unique case (cmd_e'(command_i))
      CMD_ADD: sat = clamp33(sum);
      CMD_SUB: sat = clamp33(dif);
      CMD_INC: sat = clamp33(incr);
      CMD_DEC: sat = clamp33(decr);
      CMD_DIV: begin
        if (operand_b_i == 32'd0) begin
          ctl_o.dz = 1'b1;
          sat.ovf  = 1'b1;
          sat.v    = a[31] ? SAT_MIN : SAT_MAX;
        end
      end
      CMD_LT:    ctl_o.cmp = a < b;
      CMD_GT:    ctl_o.cmp = a > b;
      CMD_LE:    ctl_o.cmp = a <= b;
      CMD_GE:    ctl_o.cmp = a >= b;
      CMD_EQ:    ctl_o.cmp = a == b;
      CMD_NE:    ctl_o.cmp = a != b;
      CMD_MIN:   sat.v = (a < b) ? operand_a_i : operand_b_i;
      CMD_MAX:   sat.v = (a > b) ? operand_a_i : operand_b_i;
      CMD_TOINT: sat.v = 32'(a >>> FRACTION_BITS);
      default:   sat = '0;
    endcase
    ctl_o.res = sat.v;
    ctl_o.ovf = sat.ovf;
  end

endmodule

[sv/fpa_div_step.sv]
module fpa_div_step #(
  parameter int unsigned NUM_W = 40
) (
  input  logic [NUM_W-1:0] num_i,
  input  logic [31:0]      rem_i,
  input  logic [31:0]      den_i,
  output logic [NUM_W-1:0] num_o,
  output logic [31:0]      rem_o
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        take;

  assign trial = {rem_i, num_i[NUM_W-1]};
  assign diff  = trial - {1'b0, den_i};
  assign take  = trial >= {1'b0, den_i};
  assign rem_o = take ? diff[31:0] : trial[31:0];
  assign num_o = {num_i[NUM_W-2:0], take};

endmodule

[sv/fpa_back.sv]
module fpa_back import fpa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FPA_FRACTION_BITS,
  localparam int unsigned NUM_W = 32 + FRACTION_BITS
) (
  input  ctl_t             ctl_i,
  input  logic [63:0]      prod_i,
  input  logic [NUM_W-1:0] quot_i,
  input  logic [31:0]      rem_i,
  input  logic [31:0]      den_i,
  output logic [31:0]      result_value_o,
  output logic             compare_true_o,
  output logic             overflowed_o,
  output logic             divide_by_zero_o
);

  logic [63:0]    prod_rnd;
  logic [NUM_W:0] quot_rnd;
  logic           round_up;
  sat_t           mul_sat;
  sat_t           div_sat;

  assign prod_rnd = (prod_i + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
  assign round_up = {rem_i, 1'b0} >= {1'b0, den_i};
  assign quot_rnd = {1'b0, quot_i} + {{NUM_W{1'b0}}, round_up};
  assign mul_sat  = clamp_mag(ctl_i.neg, prod_rnd);
  assign div_sat  = clamp_mag(ctl_i.neg, 64'(quot_rnd));

  always_comb begin
    result_value_o   = ctl_i.res;
    compare_true_o   = ctl_i.cmp;
    overflowed_o     = ctl_i.ovf;
    divide_by_zero_o = ctl_i.dz;
    if (ctl_i.cmd == CMD_MUL) begin
      result_value_o = mul_sat.v;
      overflowed_o   = mul_sat.ovf;
    end else if (ctl_i.cmd == CMD_DIV && !ctl_i.dz) begin
      result_value_o = div_sat.v;
      overflowed_o   = div_sat.ovf;
    end
  end

endmodule

[sv/fixed_point_q24_8_alu.sv]
// Signed Q24.8 fixed-point ALU with saturation.
//
// The request channel carries a command and two raw operands; a request is
// taken on a rising edge where in_valid_i is high and in_stall_o is low.
// Every request produces exactly one result on the output channel, taken
// where out_valid_o is high and out_stall_i is low.
//
// All commands pass through the same pipeline, so results leave in request
// order. The divider forms one quotient bit per stage over 32 + FRACTION_BITS
// stages. Throughput is one request per cycle while no waiting result is
// stalled by the receiver.
//
// When a result waits and the receiver stalls, the whole pipeline holds and
// in_stall_o is raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty after reset.
module fixed_point_q24_8_alu import fpa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FPA_FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o,
  output logic        compare_true_o,
  output logic        overflowed_o,
  output logic        divide_by_zero_o
);

  localparam int unsigned NUM_W = 32 + FRACTION_BITS;

  logic             adv;
  ctl_t             front_ctl;
  logic [31:0]      front_mag_a;
  logic [31:0]      front_mag_b;

  logic             vld_q  [0:NUM_W];
  ctl_t             ctl_q  [0:NUM_W];
  logic [NUM_W-1:0] num_q  [0:NUM_W];
  logic [31:0]      rem_q  [0:NUM_W];
  logic [31:0]      den_q  [0:NUM_W];
  logic [63:0]      prod_q [1:NUM_W];

  logic             out_valid_q;
  logic [31:0]      res_d, res_q;
  logic             cmp_d, cmp_q;
  logic             ovf_d, ovf_q;
  logic             dz_d, dz_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .command_i  (command_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .ctl_o      (front_ctl),
    .mag_a_o    (front_mag_a),
    .mag_b_o    (front_mag_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= front_ctl;
      num_q[0] <= {front_mag_a, {FRACTION_BITS{1'b0}}};
      rem_q[0] <= '0;
      den_q[0] <= front_mag_b;
    end
  end

  for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] num_d;
    logic [31:0]      rem_d;
    logic [63:0]      prod_d;

    fpa_div_step #(.NUM_W(NUM_W)) u_step (
      .num_i(num_q[k-1]),
      .rem_i(rem_q[k-1]),
      .den_i(den_q[k-1]),
      .num_o(num_d),
      .rem_o(rem_d)
    );

    if (k == 1) begin : g_mul
      assign prod_d = 64'(num_q[0][NUM_W-1 -: 32]) * 64'(den_q[0]);
    end else begin : g_carry
      assign prod_d = prod_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ctl_q[k]  <= ctl_q[k-1];
        num_q[k]  <= num_d;
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_q[k-1];
        prod_q[k] <= prod_d;
      end
    end
  end

  fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .ctl_i           (ctl_q[NUM_W]),
    .prod_i          (prod_q[NUM_W]),
    .quot_i          (num_q[NUM_W]),
    .rem_i           (rem_q[NUM_W]),
    .den_i           (den_q[NUM_W]),
    .result_value_o  (res_d),
    .compare_true_o  (cmp_d),
    .overflowed_o    (ovf_d),
    .divide_by_zero_o(dz_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[NUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      cmp_q <= cmp_d;
      ovf_q <= ovf_d;
      dz_q  <= dz_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_value_o   = res_q;
  assign compare_true_o   = cmp_q;
  assign overflowed_o     = ovf_q;
  assign divide_by_zero_o = dz_q;

endmodule

[sv/fpa_checker.sv]
module fpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] result_value_o,
  input logic        compare_true_o,
  input logic        overflowed_o,
  input logic        divide_by_zero_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o))
    else $error("result dropped or changed while stalled");

  a_dz_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> overflowed_o)
    else $error("division by zero without saturation flag");

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_true_o |-> result_value_o == 32'd0 && !overflowed_o)
    else $error("comparison result carries a value");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without a waiting result");

endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_value_o  (result_value_o),
  .compare_true_o  (compare_true_o),
  .overflowed_o    (overflowed_o),
  .divide_by_zero_o(divide_by_zero_o)
);

[test/fixed_point_q24_8_alu_test.sv]
module fixed_point_q24_8_alu_test import fpa_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB = FPA_FRACTION_BITS;
  localparam int unsigned LATENCY = FB + 33;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic [3:0] CMD_UNKNOWN = 4'd15;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        ovf;
    logic        dz;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending_q[$];
    int unsigned mismatches;

    function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag,
                                            ref logic ovf);
      if (neg) begin
        if (mag > 64'h8000_0000) begin
          ovf = 1'b1;
          return SAT_MIN;
        end
        return 32'd0 - mag[31:0];
      end
      if (mag > 64'h7FFF_FFFF) begin
        ovf = 1'b1;
        return SAT_MAX;
      end
      return mag[31:0];
    endfunction

    function automatic logic [31:0] sat_sum(input logic signed [63:0] x, ref logic ovf);
      if (x > 64'sd2147483647) begin
        ovf = 1'b1;
        return SAT_MAX;
      end
      if (x < -64'sd2147483648) begin
        ovf = 1'b1;
        return SAT_MIN;
      end
      return x[31:0];
    endfunction

    function automatic alu_result_t compute(input logic [3:0] cmd,
                                            input logic [31:0] ra, input logic [31:0] rb);
      alu_result_t r;
      logic signed [63:0] a, b;
      logic [63:0] ma, mb, m, num, q, rem;
      logic neg, ovf;
      a = 64'(signed'(ra));
      b = 64'(signed'(rb));
      ma = a < 0 ? 64'(-a) : 64'(a);
      mb = b < 0 ? 64'(-b) : 64'(b);
      neg = (a < 0) != (b < 0);
      ovf = 1'b0;
      r = '0;
      case (cmd)
        CMD_ADD: r.value = sat_sum(a + b, ovf);
        CMD_SUB: r.value = sat_sum(a - b, ovf);
        CMD_MUL: begin
          m = ma * mb;
          q = (m + (64'd1 << (FB - 1))) >> FB;
          r.value = sat_mag(neg, q, ovf);
        end
        CMD_DIV: begin
          if (b == 0) begin
            r.dz = 1'b1;
            ovf = 1'b1;
            r.value = a < 0 ? SAT_MIN : SAT_MAX;
          end else begin
            num = ma << FB;
            q = num / mb;
            rem = num % mb;
            if (2 * rem >= mb) q = q + 1;
            r.value = sat_mag(neg, q, ovf);
          end
        end
        CMD_LT: r.cmp = a < b;
        CMD_GT: r.cmp = a > b;
        CMD_LE: r.cmp = a <= b;
        CMD_GE: r.cmp = a >= b;
        CMD_EQ: r.cmp = a == b;
        CMD_NE: r.cmp = a != b;
        CMD_MIN: r.value = a < b ? ra : rb;
        CMD_MAX: r.value = a > b ? ra : rb;
        CMD_INC: r.value = sat_sum(a + 1, ovf);
        CMD_DEC: r.value = sat_sum(a - 1, ovf);
        CMD_TOINT: r.value = 32'($signed(ra) >>> FB);
        default: r = '0;
      endcase
      r.ovf = ovf;
      return r;
    endfunction

    function void note_request(input logic [3:0] cmd, input logic [31:0] a,
                               input logic [31:0] b);
      pending_q.push_back(compute(cmd, a, b));
    endfunction

    function void check_result(input alu_result_t got);
      alu_result_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected value %h cmp %b ovf %b dz %b, got %h %b %b %b",
                   want.value, want.cmp, want.ovf, want.dz,
                   got.value, got.cmp, got.ovf, got.dz);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] command_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] result_value_o;
  logic compare_true_o, overflowed_o, divide_by_zero_o;

  alu_scoreboard board = new();
  bit quiet_mode = 1'b0;
  bit hold_off = 1'b0;
  bit done_sending = 1'b0;
  int unsigned idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  fixed_point_q24_8_alu u_top (.*);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_request(command_i, operand_a_i, operand_b_i);
      if (out_valid_o && !out_stall_i)
        board.check_result({result_value_o, compare_true_o, overflowed_o,
                            divide_by_zero_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("fixed_point_q24_8_alu test failed");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else if (hold_off) out_stall_i <= 1'b1;
    else if (quiet_mode) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 6);
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(2048)) - 1024);
      4: return 32'($urandom_range(8)) << FB;
      5: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [3:0] cmd, input logic [31:0] a,
                              input logic [31:0] b);
    while (!quiet_mode && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [3:0] c;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i <= 15; i++)
      send_request(4'(i), 32'h0000_0180, 32'hFFFF_FE80);
    send_request(CMD_DIV, 32'h0000_0500, 32'd0);
    send_request(CMD_DIV, 32'hFFFF_FB00, 32'd0);
    send_request(CMD_DIV, 32'd0, 32'd0);
    send_request(CMD_INC, SAT_MAX, 32'd0);
    send_request(CMD_DEC, SAT_MIN, 32'd0);
    send_request(CMD_MUL, SAT_MIN, SAT_MIN);
    send_request(CMD_ADD, SAT_MAX, SAT_MAX);
    send_request(CMD_SUB, SAT_MIN, SAT_MAX);
    send_request(CMD_TOINT, SAT_MIN, SAT_MAX);
    for (int i = 0; i < 850; i++) begin
      quiet_mode = (i >= 300 && i < 450);
      if (i == 500) fork
        begin
          hold_off = 1'b1;
          repeat (150) @(posedge clk_i);
          hold_off = 1'b0;
        end
      join_none
      c = ($urandom_range(49) == 0) ? CMD_UNKNOWN : 4'($urandom_range(14));
      send_request(c, pick_operand(), pick_operand());
    end
    quiet_mode = 1'b0;
    in_valid_i <= 1'b0;
    done_sending = 1'b1;
  end

  initial begin : finish_check
    wait (done_sending);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_q.size() == 0)
      $display("fixed_point_q24_8_alu test passed");
    else
      $display("fixed_point_q24_8_alu test failed");
    $finish;
  end
endmodule
